// ===== rtl/core/adsr_pkg.sv =====
`timescale 1ns / 1ps

package adsr_pkg;

   // Gain is unsigned Q0.16 and reaches unity, so it needs one extra bit.
   localparam int GAIN_BITS = 17;
   localparam int FRAC_BITS = 16;
   localparam logic [GAIN_BITS-1:0] UNITY_GAIN = 17'h10000;

   localparam int CSR_INDEX_BITS = 3;
   localparam int NOTE_LENGTH_RESET = 44100;
   localparam logic [7:0] FRACTION_MAX = 8'd255;
   localparam logic [7:0] SUSTAIN_RESET = 8'd255;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_NOTE_LENGTH = 3'd0,
      REG_ATTACK      = 3'd1,
      REG_DECAY       = 3'd2,
      REG_SUSTAIN     = 3'd3,
      REG_RELEASE     = 3'd4
   } csr_reg_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_ACCEPT,
      OP_SEG_MUL,
      OP_SEG_LOAD,
      OP_SEG_STORE,
      OP_GAIN_MUL,
      OP_GAIN_LOAD,
      OP_GAIN_STORE,
      OP_REL_MUL,
      OP_REL_LOAD,
      OP_REL_STORE,
      OP_OUT_MUL,
      OP_OUT_WRITE
   } dp_op_type;

   typedef enum logic [1:0] {
      SEG_ATTACK,
      SEG_DECAY,
      SEG_RELEASE
   } seg_sel_type;

   typedef struct packed {
      logic        take;
      dp_op_type   op;
      seg_sel_type seg;
   } dp_cmd_type;

   typedef struct packed {
      logic req_valid;
      logic seg_dirty;
      logic gain_div;
      logic rel_active;
      logic div_busy;
      logic out_free;
   } dp_status_type;

endpackage

// ===== rtl/core/adsr_if.sv =====
`timescale 1ns / 1ps

interface adsr_req_if #(
   parameter int SAMPLE_BITS = 16
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample_in;

   modport source (output valid, output sample_in, input ready);
   modport sink (input valid, input sample_in, output ready);
endinterface

interface adsr_rsp_if #(
   parameter int SAMPLE_BITS = 16
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample_out;
   logic                          note_end;

   modport source (output valid, output sample_out, output note_end, input ready);
   modport sink (input valid, input sample_out, input note_end, output ready);
endinterface

interface adsr_csr_if #(
   parameter int DATA_BITS = 20
);
   logic                                    valid;
   logic                                    ready;
   logic [adsr_pkg::CSR_INDEX_BITS-1:0]     index;
   logic [DATA_BITS-1:0]                    data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/adsr_div.sv =====
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle. The caller pre-aligns the
// dividend: the partial remainder starts below the divisor and the remaining
// dividend bits sit left-aligned in low_init.
module adsr_div #(
   parameter int DEN_W = 28,
   parameter int QUO_W = 20,
   parameter int CNT_W = 5
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DEN_W-1:0] rem_init,
   input  logic [QUO_W-1:0] low_init,
   input  logic [CNT_W-1:0] iters,
   input  logic [DEN_W-1:0] den,
   output logic             busy,
   output logic [QUO_W-1:0] quo
);

   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [QUO_W-1:0] low_ff, low_in;
   logic [QUO_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic [DEN_W:0]   trial;
   logic [DEN_W:0]   diff;
   logic             fits;

   always_comb begin
      trial = {rem_ff, low_ff[QUO_W-1]};
      diff = trial - {1'b0, den_ff};
      fits = trial >= {1'b0, den_ff};
      rem_in = rem_ff;
      low_in = low_ff;
      quo_in = quo_ff;
      den_in = den_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         rem_in = rem_init;
         low_in = low_init;
         quo_in = '0;
         den_in = den;
         cnt_in = iters;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         low_in = low_ff << 1;
         quo_in = {quo_ff[QUO_W-2:0], fits};
         cnt_in = cnt_ff - CNT_W'(1);
         busy_in = cnt_ff != CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      low_ff <= low_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
   end

   assign busy = busy_ff;
   assign quo = quo_ff;

endmodule

// ===== rtl/core/adsr_dp.sv =====
`timescale 1ns / 1ps

module adsr_dp #(
   parameter int INDEX_BITS = 20,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  adsr_pkg::dp_cmd_type                cmd,
   output adsr_pkg::dp_status_type             status,
   input  logic                                req_valid,
   input  logic signed [SAMPLE_BITS-1:0]       req_sample,
   input  logic                                csr_valid,
   input  logic [adsr_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [INDEX_BITS-1:0]               csr_data,
   input  logic                                rsp_ready,
   output logic                                rsp_valid,
   output logic signed [SAMPLE_BITS-1:0]       rsp_sample,
   output logic                                rsp_note_end
);

   localparam int GB = adsr_pkg::GAIN_BITS;
   localparam int PROD_W = INDEX_BITS + GB;
   localparam int DEN_W = INDEX_BITS + 8;
   localparam int QUO_W = (INDEX_BITS > GB) ? INDEX_BITS : GB;
   localparam int CNT_W = $clog2(QUO_W + 1);
   localparam int MUL_W = SAMPLE_BITS + GB + 1;
   localparam int SEG_DIG = (DEN_W + 7) / 8;
   localparam int SEG_W = 8 * SEG_DIG;
   localparam int SEG_CNT_W = $clog2(SEG_DIG + 1);

   logic [INDEX_BITS-1:0]        len_ff;
   logic [7:0]                   atk_frac_ff;
   logic [7:0]                   dec_frac_ff;
   logic [7:0]                   sus_ff;
   logic [7:0]                   rel_frac_ff;
   logic                         seg_dirty_ff;
   logic [INDEX_BITS-1:0]        a_ff;
   logic [INDEX_BITS-1:0]        d_ff;
   logic [INDEX_BITS-1:0]        r_ff;
   logic [INDEX_BITS-1:0]        idx_ff;
   logic [INDEX_BITS-1:0]        ci_ff;
   logic                         last_ff;
   logic                         attack_ff;
   logic signed [SAMPLE_BITS-1:0] smp_ff;
   logic [GB-1:0]                gain_ff;
   logic [PROD_W-1:0]            prod_ff;
   logic [DEN_W-1:0]             den_ff;
   logic signed [MUL_W-1:0]      outp_ff;
   logic                         rsp_valid_ff;
   logic signed [SAMPLE_BITS-1:0] rsp_sample_ff;
   logic                         rsp_note_end_ff;
   logic [SEG_W-1:0]             seg_num_ff;
   logic [SEG_W-1:0]             seg_quo_ff;
   logic [7:0]                   seg_rem_ff;
   logic [SEG_CNT_W-1:0]         seg_cnt_ff;
   logic                         seg_busy_ff;

   logic [INDEX_BITS-1:0] len_eff;
   logic [INDEX_BITS-1:0] len_last;
   logic [INDEX_BITS-1:0] ci_new;
   logic [INDEX_BITS:0]   ad_end;
   logic                  in_attack;
   logic                  in_decay;
   logic                  rel_active;
   logic [7:0]            seg_frac;
   logic [GB-1:0]         sus_gain;
   logic signed [MUL_W-1:0] smp_ext;
   logic signed [MUL_W-1:0] gain_ext;
   logic [8:0]            seg_sum;
   logic                  seg_fits;

   logic                  div_start;
   logic [DEN_W-1:0]      div_rem;
   logic [QUO_W-1:0]      div_low;
   logic [CNT_W-1:0]      div_iters;
   logic [DEN_W-1:0]      div_den;
   logic                  div_busy;
   logic [QUO_W-1:0]      quo;

   always_comb begin
      len_eff = (len_ff == '0) ? INDEX_BITS'(1) : len_ff;
      len_last = len_eff - INDEX_BITS'(1);
      // an index left past the end by a shortened note is pinned to the last sample
      ci_new = (idx_ff >= len_eff) ? len_last : idx_ff;
      ad_end = {1'b0, a_ff} + {1'b0, d_ff};
      in_attack = ci_ff < a_ff;
      in_decay = !in_attack && ({1'b0, ci_ff} < ad_end);
      rel_active = (r_ff != '0) && (ci_ff >= (len_eff - r_ff));
      case (cmd.seg)
         adsr_pkg::SEG_ATTACK: seg_frac = atk_frac_ff;
         adsr_pkg::SEG_DECAY:  seg_frac = dec_frac_ff;
         default:              seg_frac = rel_frac_ff;
      endcase
      // S*65536/255 is S*257, plus one when S is full scale
      sus_gain = {1'b0, sus_ff, sus_ff} + GB'(sus_ff == adsr_pkg::FRACTION_MAX);
      smp_ext = MUL_W'(smp_ff);
      gain_ext = $signed(MUL_W'(gain_ff));
   end

   always_comb begin
      div_start = (cmd.op == adsr_pkg::OP_GAIN_LOAD) || (cmd.op == adsr_pkg::OP_REL_LOAD);
      case (cmd.op)
         adsr_pkg::OP_REL_LOAD: begin
            div_rem = DEN_W'(prod_ff >> GB);
            div_low = QUO_W'(prod_ff[GB-1:0]) << (QUO_W - GB);
            div_iters = CNT_W'(GB);
            div_den = DEN_W'(r_ff);
         end
         default: begin
            // attack and decay: the dividend is prod_ff shifted up by the fraction bits
            div_rem = DEN_W'(prod_ff);
            div_low = '0;
            div_iters = CNT_W'(adsr_pkg::FRAC_BITS);
            div_den = den_ff;
         end
      endcase
   end

   adsr_div #(
      .DEN_W(DEN_W),
      .QUO_W(QUO_W),
      .CNT_W(CNT_W)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .rem_init(div_rem),
      .low_init(div_low),
      .iters   (div_iters),
      .den     (div_den),
      .busy    (div_busy),
      .quo     (quo)
   );

   // Divide a segment product by 255 a byte per cycle: 256 is 255 plus one, so
   // each quotient digit is the running remainder plus a carry.
   always_comb begin
      seg_sum = {1'b0, seg_rem_ff} + {1'b0, seg_num_ff[SEG_W-1 -: 8]};
      seg_fits = seg_sum >= {1'b0, adsr_pkg::FRACTION_MAX};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_busy_ff <= 1'b0;
      end else if (cmd.op == adsr_pkg::OP_SEG_LOAD) begin
         seg_busy_ff <= 1'b1;
      end else if (seg_busy_ff) begin
         seg_busy_ff <= seg_cnt_ff != SEG_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == adsr_pkg::OP_SEG_LOAD) begin
         seg_num_ff <= SEG_W'(prod_ff[DEN_W-1:0]);
         seg_quo_ff <= '0;
         seg_rem_ff <= '0;
         seg_cnt_ff <= SEG_CNT_W'(SEG_DIG);
      end else if (seg_busy_ff) begin
         seg_num_ff <= seg_num_ff << 8;
         seg_quo_ff <= {seg_quo_ff[SEG_W-9:0], seg_rem_ff + 8'(seg_fits)};
         seg_rem_ff <= seg_fits ? 8'(seg_sum - {1'b0, adsr_pkg::FRACTION_MAX})
            : seg_sum[7:0];
         seg_cnt_ff <= seg_cnt_ff - SEG_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= INDEX_BITS'(adsr_pkg::NOTE_LENGTH_RESET);
         atk_frac_ff <= '0;
         dec_frac_ff <= '0;
         sus_ff <= adsr_pkg::SUSTAIN_RESET;
         rel_frac_ff <= '0;
         seg_dirty_ff <= 1'b1;
         idx_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (cmd.op)
            adsr_pkg::OP_SEG_STORE: begin
               if (cmd.seg == adsr_pkg::SEG_RELEASE) begin
                  seg_dirty_ff <= 1'b0;
               end
            end
            adsr_pkg::OP_OUT_WRITE: begin
               idx_ff <= last_ff ? '0 : ci_ff + INDEX_BITS'(1);
            end
            default: ;
         endcase
         if (cmd.op == adsr_pkg::OP_OUT_WRITE) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         // segment lengths follow the registers, so mark them stale on any write
         if (csr_valid) begin
            seg_dirty_ff <= 1'b1;
            unique case (csr_index)
               adsr_pkg::REG_NOTE_LENGTH: len_ff <= csr_data;
               adsr_pkg::REG_ATTACK:      atk_frac_ff <= csr_data[7:0];
               adsr_pkg::REG_DECAY:       dec_frac_ff <= csr_data[7:0];
               adsr_pkg::REG_SUSTAIN:     sus_ff <= csr_data[7:0];
               adsr_pkg::REG_RELEASE:     rel_frac_ff <= csr_data[7:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      unique case (cmd.op)
         adsr_pkg::OP_ACCEPT: begin
            smp_ff <= req_sample;
            ci_ff <= ci_new;
            last_ff <= ci_new == len_last;
         end
         adsr_pkg::OP_SEG_MUL: begin
            prod_ff <= PROD_W'(seg_frac) * PROD_W'(len_eff);
         end
         adsr_pkg::OP_SEG_STORE: begin
            case (cmd.seg)
               adsr_pkg::SEG_ATTACK: a_ff <= seg_quo_ff[INDEX_BITS-1:0];
               adsr_pkg::SEG_DECAY:  d_ff <= seg_quo_ff[INDEX_BITS-1:0];
               default:              r_ff <= seg_quo_ff[INDEX_BITS-1:0];
            endcase
         end
         adsr_pkg::OP_GAIN_MUL: begin
            attack_ff <= in_attack;
            gain_ff <= sus_gain;
            if (in_attack) begin
               prod_ff <= PROD_W'(ci_ff);
               den_ff <= DEN_W'(a_ff);
            end else begin
               prod_ff <= PROD_W'(adsr_pkg::FRACTION_MAX - sus_ff) * PROD_W'(ci_ff - a_ff);
               den_ff <= (DEN_W'(d_ff) << 8) - DEN_W'(d_ff);
            end
         end
         adsr_pkg::OP_GAIN_STORE: begin
            gain_ff <= attack_ff ? quo[GB-1:0] : adsr_pkg::UNITY_GAIN - quo[GB-1:0];
         end
         adsr_pkg::OP_REL_MUL: begin
            prod_ff <= PROD_W'(gain_ff) * PROD_W'(len_eff - ci_ff);
         end
         adsr_pkg::OP_REL_STORE: begin
            gain_ff <= quo[GB-1:0];
         end
         adsr_pkg::OP_OUT_MUL: begin
            outp_ff <= smp_ext * gain_ext;
         end
         adsr_pkg::OP_OUT_WRITE: begin
            // arithmetic shift floors toward minus infinity
            rsp_sample_ff <= outp_ff[SAMPLE_BITS+adsr_pkg::FRAC_BITS-1:adsr_pkg::FRAC_BITS];
            rsp_note_end_ff <= last_ff;
         end
         default: ;
      endcase
   end

   always_comb begin
      status.req_valid = req_valid;
      status.seg_dirty = seg_dirty_ff;
      status.gain_div = in_attack || in_decay;
      status.rel_active = rel_active;
      status.div_busy = div_busy || seg_busy_ff;
      status.out_free = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_sample = rsp_sample_ff;
   assign rsp_note_end = rsp_note_end_ff;

endmodule

// ===== rtl/core/adsr_ctrl.sv =====
`timescale 1ns / 1ps

module adsr_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  adsr_pkg::dp_status_type status,
   output adsr_pkg::dp_cmd_type    cmd
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SEG_MUL,
      ST_SEG_LOAD,
      ST_SEG_RUN,
      ST_GAIN_MUL,
      ST_GAIN_LOAD,
      ST_GAIN_RUN,
      ST_REL_MUL,
      ST_REL_LOAD,
      ST_REL_RUN,
      ST_OUT_MUL,
      ST_OUT_WRITE
   } state_type;

   state_type             state_ff, state_in;
   adsr_pkg::seg_sel_type seg_ff, seg_in;

   always_comb begin
      state_in = state_ff;
      seg_in = seg_ff;
      cmd.take = 1'b0;
      cmd.op = adsr_pkg::OP_NONE;
      cmd.seg = seg_ff;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.take = 1'b1;
            if (status.req_valid) begin
               cmd.op = adsr_pkg::OP_ACCEPT;
               if (status.seg_dirty) begin
                  seg_in = adsr_pkg::SEG_ATTACK;
                  state_in = ST_SEG_MUL;
               end else begin
                  state_in = ST_GAIN_MUL;
               end
            end
         end
         ST_SEG_MUL: begin
            cmd.op = adsr_pkg::OP_SEG_MUL;
            state_in = ST_SEG_LOAD;
         end
         ST_SEG_LOAD: begin
            cmd.op = adsr_pkg::OP_SEG_LOAD;
            state_in = ST_SEG_RUN;
         end
         ST_SEG_RUN: begin
            if (!status.div_busy) begin
               cmd.op = adsr_pkg::OP_SEG_STORE;
               if (seg_ff == adsr_pkg::SEG_RELEASE) begin
                  state_in = ST_GAIN_MUL;
               end else begin
                  seg_in = (seg_ff == adsr_pkg::SEG_ATTACK) ? adsr_pkg::SEG_DECAY
                     : adsr_pkg::SEG_RELEASE;
                  state_in = ST_SEG_MUL;
               end
            end
         end
         ST_GAIN_MUL: begin
            cmd.op = adsr_pkg::OP_GAIN_MUL;
            state_in = status.gain_div ? ST_GAIN_LOAD : ST_REL_MUL;
         end
         ST_GAIN_LOAD: begin
            cmd.op = adsr_pkg::OP_GAIN_LOAD;
            state_in = ST_GAIN_RUN;
         end
         ST_GAIN_RUN: begin
            if (!status.div_busy) begin
               cmd.op = adsr_pkg::OP_GAIN_STORE;
               state_in = ST_REL_MUL;
            end
         end
         ST_REL_MUL: begin
            // skip the release scaling outside the tail of the note
            if (status.rel_active) begin
               cmd.op = adsr_pkg::OP_REL_MUL;
               state_in = ST_REL_LOAD;
            end else begin
               state_in = ST_OUT_MUL;
            end
         end
         ST_REL_LOAD: begin
            cmd.op = adsr_pkg::OP_REL_LOAD;
            state_in = ST_REL_RUN;
         end
         ST_REL_RUN: begin
            if (!status.div_busy) begin
               cmd.op = adsr_pkg::OP_REL_STORE;
               state_in = ST_OUT_MUL;
            end
         end
         ST_OUT_MUL: begin
            cmd.op = adsr_pkg::OP_OUT_MUL;
            state_in = ST_OUT_WRITE;
         end
         ST_OUT_WRITE: begin
            // hold until the output register is free
            if (status.out_free) begin
               cmd.op = adsr_pkg::OP_OUT_WRITE;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         seg_ff <= adsr_pkg::SEG_ATTACK;
      end else begin
         state_ff <= state_in;
         seg_ff <= seg_in;
      end
   end

endmodule

// ===== rtl/core/adsr_envelope_shaper_top.sv =====
`timescale 1ns / 1ps

// Linear ADSR envelope shaper: one signed sample in, one shaped sample out.
// req_if carries sample_in; rsp_if returns sample_out and note_end, which is
// set on the last sample of each note. csr_if writes the registers by index
// (note length, attack, decay, sustain, release) and is always ready; write
// them only while no sample is in flight.
// One sample is worked at a time. Outside attack, decay and release a result
// needs no divide; the attack or decay divide (16 steps) and the release
// divide (17 steps) both run on the shared serial divider. The first sample
// after a register write also recomputes the three segment lengths, one
// dividend byte per cycle. The next sample is taken in the cycle after a
// result is written.
// The result sits in an output register; the next sample is accepted while it
// waits, and that sample's own result holds until the receiver takes the
// previous one. Reset restores the register defaults, puts the sample index
// at the start of a note and empties the output.
module adsr_envelope_shaper_top #(
   parameter int INDEX_BITS = 20,
   parameter int SAMPLE_BITS = 16
) (
   input logic         clock,
   input logic         reset,
   adsr_req_if.sink    req_if,
   adsr_rsp_if.source  rsp_if,
   adsr_csr_if.sink    csr_if
);

   adsr_pkg::dp_cmd_type    cmd;
   adsr_pkg::dp_status_type status;

   assign req_if.ready = cmd.take;
   assign csr_if.ready = 1'b1;

   adsr_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .status(status),
      .cmd   (cmd)
   );

   adsr_dp #(
      .INDEX_BITS (INDEX_BITS),
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_valid   (req_if.valid),
      .req_sample  (req_if.sample_in),
      .csr_valid   (csr_if.valid),
      .csr_index   (csr_if.index),
      .csr_data    (csr_if.data),
      .rsp_ready   (rsp_if.ready),
      .rsp_valid   (rsp_if.valid),
      .rsp_sample  (rsp_if.sample_out),
      .rsp_note_end(rsp_if.note_end)
   );

endmodule

// ===== rtl/core/adsr_checker.sv =====
`timescale 1ns / 1ps

module adsr_checker #(
   parameter int SAMPLE_BITS = 16
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic signed [SAMPLE_BITS-1:0] sample_out,
   input logic                          note_end
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped before transfer");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(sample_out) && $stable(note_end))
      else $error("stalled result changed");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second sample taken while one is in work");

   a_reset_empty: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind adsr_envelope_shaper_top adsr_checker #(
   .SAMPLE_BITS(SAMPLE_BITS)
) u_adsr_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_if.valid),
   .req_ready (req_if.ready),
   .rsp_valid (rsp_if.valid),
   .rsp_ready (rsp_if.ready),
   .sample_out(rsp_if.sample_out),
   .note_end  (rsp_if.note_end)
);

// ===== tb/adsr_envelope_shaper_top_tb.sv =====
`timescale 1ns / 1ps

module adsr_envelope_shaper_top_tb;

   localparam int IDX_W = 20;
   localparam int SMP_W = 16;
   localparam int RANDOM_ITEMS = 1700;
   localparam int IDLE_LIMIT = 2000;
   localparam int TAIL_CYCLES = 120;
   localparam logic [adsr_pkg::CSR_INDEX_BITS-1:0] REG_SPARE_FIRST = 3'd5;
   localparam logic [adsr_pkg::CSR_INDEX_BITS-1:0] REG_SPARE_LAST = 3'd7;
   localparam logic [IDX_W-1:0] NOTE_MAX = '1;

   typedef struct {
      logic signed [SMP_W-1:0] sample_out;
      logic                    note_end;
   } shaped_type;

   typedef struct {
      logic signed [SMP_W-1:0] sample;
      bit                      wait_drain;
   } pending_type;

   typedef struct {
      logic [adsr_pkg::CSR_INDEX_BITS-1:0] index;
      logic [IDX_W-1:0]                    data;
   } reg_write_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   adsr_req_if #(.SAMPLE_BITS(SMP_W)) req_ch ();
   adsr_rsp_if #(.SAMPLE_BITS(SMP_W)) rsp_ch ();
   adsr_csr_if #(.DATA_BITS(IDX_W))   csr_ch ();

   adsr_envelope_shaper_top #(
      .INDEX_BITS(IDX_W),
      .SAMPLE_BITS(SMP_W)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_if(req_ch),
      .rsp_if(rsp_ch),
      .csr_if(csr_ch)
   );

   // Envelope state as the block should hold it
   logic [IDX_W-1:0] note_length_q;
   logic [7:0]       attack_q;
   logic [7:0]       decay_q;
   logic [7:0]       sustain_q;
   logic [7:0]       release_q;
   logic [IDX_W-1:0] note_pos;

   pending_type   pending_samples[$];
   shaped_type    expected_shaped[$];
   reg_write_type reg_writes[$];

   int samples_sent = 0;
   int results_taken = 0;
   int failures = 0;
   int quiet_cycles = 0;
   int req_gap = 0;
   int rsp_stall = 0;
   bit req_calm = 1'b0;
   bit rsp_calm = 1'b0;
   int random_total;
   int burst;
   pending_type next_item;
   shaped_type  got_shape;
   shaped_type  want_shape;

   function automatic shaped_type shape_sample(input logic signed [SMP_W-1:0] smp);
      longint unsigned len, i, a, d, r, s, g, full, unity;
      longint          prod;
      shaped_type      res;
      full = 64'(adsr_pkg::FRACTION_MAX);
      unity = 64'(adsr_pkg::UNITY_GAIN);
      len = (note_length_q == '0) ? 64'd1 : 64'(note_length_q);
      i = 64'(note_pos);
      if (i >= len) i = len - 1;   // clamp an index left past a shortened note
      s = 64'(sustain_q);
      a = 64'(attack_q) * len / full;
      d = 64'(decay_q) * len / full;
      r = 64'(release_q) * len / full;
      if (i < a) begin
         g = i * unity / a;
      end else if (i < a + d) begin
         g = unity - (full - s) * (i - a) * unity / (full * d);
      end else begin
         g = s * unity / full;
      end
      if (r != 0 && i >= len - r) g = g * (len - i) / r;
      prod = longint'(smp) * longint'(g);
      res.sample_out = SMP_W'(prod >>> adsr_pkg::FRAC_BITS);
      res.note_end = (i == len - 1);
      note_pos = res.note_end ? '0 : IDX_W'(i + 1);
      return res;
   endfunction

   function automatic void apply_register(input logic [adsr_pkg::CSR_INDEX_BITS-1:0] idx,
                                          input logic [IDX_W-1:0] data);
      case (idx)
         adsr_pkg::REG_NOTE_LENGTH: note_length_q = data;
         adsr_pkg::REG_ATTACK:      attack_q = data[7:0];
         adsr_pkg::REG_DECAY:       decay_q = data[7:0];
         adsr_pkg::REG_SUSTAIN:     sustain_q = data[7:0];
         adsr_pkg::REG_RELEASE:     release_q = data[7:0];
         default: ;
      endcase
   endfunction

   function automatic int pick_wait(inout bit calm);
      if ($urandom_range(0, 15) == 0) calm = !calm;
      return calm ? 0 : int'($urandom_range(0, 5));
   endfunction

   function automatic logic [IDX_W-1:0] pick_length();
      case ($urandom_range(0, 19))
         0:          return '0;
         1:          return NOTE_MAX;
         2:          return IDX_W'($urandom);
         3, 4, 5, 6: return IDX_W'($urandom_range(65, 400));
         default:    return IDX_W'($urandom_range(1, 64));
      endcase
   endfunction

   function automatic logic [7:0] pick_fraction();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return adsr_pkg::FRACTION_MAX;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic logic signed [SMP_W-1:0] random_sample();
      case ($urandom_range(0, 7))
         0:       return 16'sh7FFF;
         1:       return 16'sh8000;
         2:       return SMP_W'(int'($urandom_range(0, 16)) - 8);
         default: return SMP_W'($urandom);
      endcase
   endfunction

   function automatic void add_sample(input logic signed [SMP_W-1:0] smp,
                                      input bit wait_drain);
      pending_samples.push_back('{smp, wait_drain});
   endfunction

   function automatic void queue_write(input logic [adsr_pkg::CSR_INDEX_BITS-1:0] idx,
                                       input logic [IDX_W-1:0] data);
      reg_writes.push_back('{idx, data});
   endfunction

   // Hold valid across back-to-back writes; drop it after the last transfer.
   task automatic write_registers();
      reg_write_type w;
      while (reg_writes.size() > 0) begin
         w = reg_writes.pop_front();
         csr_ch.valid <= 1'b1;
         csr_ch.index <= w.index;
         csr_ch.data <= w.data;
         do @(posedge clock); while (!csr_ch.ready);
         apply_register(w.index, w.data);
      end
      csr_ch.valid <= 1'b0;
   endtask

   task automatic drain();
      do @(posedge clock);
      while (pending_samples.size() != 0 || req_ch.valid || samples_sent != results_taken);
   endtask

   // Sample driver
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         req_ch.sample_in <= '0;
         req_gap = 0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            expected_shaped.push_back(shape_sample(req_ch.sample_in));
            samples_sent++;
         end
         if (req_ch.valid && !req_ch.ready) begin
            // hold the offered sample
         end else if (req_gap > 0) begin
            req_gap--;
            req_ch.valid <= 1'b0;
         end else if (pending_samples.size() > 0 &&
                      !(pending_samples[0].wait_drain && samples_sent != results_taken)) begin
            next_item = pending_samples.pop_front();
            req_ch.valid <= 1'b1;
            req_ch.sample_in <= next_item.sample;
            req_gap = pick_wait(req_calm);
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // Result monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         rsp_stall = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got_shape.sample_out = rsp_ch.sample_out;
            got_shape.note_end = rsp_ch.note_end;
            if (expected_shaped.size() == 0) begin
               $error("result with no sample pending: sample_out %0d note_end %0b",
                      got_shape.sample_out, got_shape.note_end);
               failures++;
            end else begin
               want_shape = expected_shaped.pop_front();
               results_taken <= results_taken + 1;
               if (got_shape.sample_out !== want_shape.sample_out) begin
                  $error("sample_out mismatch: expected %0d, got %0d",
                         want_shape.sample_out, got_shape.sample_out);
                  failures++;
               end
               if (got_shape.note_end !== want_shape.note_end) begin
                  $error("note_end mismatch: expected %0b, got %0b",
                         want_shape.note_end, got_shape.note_end);
                  failures++;
               end
            end
            rsp_stall = pick_wait(rsp_calm);
         end
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // Watchdog: any transfer on any channel counts as progress
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= IDLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   initial begin
      req_ch.valid = 1'b0;
      req_ch.sample_in = '0;
      rsp_ch.ready = 1'b0;
      csr_ch.valid = 1'b0;
      csr_ch.index = adsr_pkg::REG_NOTE_LENGTH;
      csr_ch.data = '0;
      note_length_q = IDX_W'(adsr_pkg::NOTE_LENGTH_RESET);
      attack_q = '0;
      decay_q = '0;
      sustain_q = adsr_pkg::SUSTAIN_RESET;
      release_q = '0;
      note_pos = '0;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: unity gain, sample extremes
      add_sample(16'sh7FFF, 1'b0);
      add_sample(16'sh8000, 1'b0);
      add_sample(16'sh0000, 1'b0);
      add_sample(16'shFFFF, 1'b0);
      drain();

      // One-sample note entered mid-note: index past the end
      queue_write(adsr_pkg::REG_NOTE_LENGTH, IDX_W'(1));
      write_registers();
      add_sample(16'sh4000, 1'b0);
      drain();

      // Zero length acts as one
      queue_write(adsr_pkg::REG_NOTE_LENGTH, '0);
      write_registers();
      add_sample(16'sh8000, 1'b0);
      add_sample(16'sh7FFF, 1'b0);
      drain();

      // Two samples in each of attack, decay, sustain and release
      queue_write(adsr_pkg::REG_NOTE_LENGTH, IDX_W'(8));
      queue_write(adsr_pkg::REG_ATTACK, IDX_W'(64));
      queue_write(adsr_pkg::REG_DECAY, IDX_W'(64));
      queue_write(adsr_pkg::REG_SUSTAIN, IDX_W'(128));
      queue_write(adsr_pkg::REG_RELEASE, IDX_W'(64));
      write_registers();
      for (int k = 0; k < 8; k++) add_sample(k[0] ? 16'sh7FFF : 16'sh8000, 1'b0);
      drain();

      // Attack spans the note and overlaps release; empty decay
      queue_write(adsr_pkg::REG_NOTE_LENGTH, IDX_W'(6));
      queue_write(adsr_pkg::REG_ATTACK, IDX_W'(adsr_pkg::FRACTION_MAX));
      queue_write(adsr_pkg::REG_DECAY, '0);
      queue_write(adsr_pkg::REG_RELEASE, IDX_W'(128));
      write_registers();
      repeat (4) add_sample(16'sh7FFF, 1'b0);
      drain();

      // Shorten the note below the current index
      queue_write(adsr_pkg::REG_NOTE_LENGTH, IDX_W'(2));
      write_registers();
      add_sample(16'sh8000, 1'b0);
      drain();

      // Longest note, full fractions, zero sustain, write to an unused index
      queue_write(adsr_pkg::REG_NOTE_LENGTH, NOTE_MAX);
      queue_write(adsr_pkg::REG_DECAY, IDX_W'(adsr_pkg::FRACTION_MAX));
      queue_write(adsr_pkg::REG_SUSTAIN, '0);
      queue_write(adsr_pkg::REG_RELEASE, IDX_W'(adsr_pkg::FRACTION_MAX));
      queue_write(REG_SPARE_FIRST, IDX_W'($urandom));
      write_registers();
      add_sample(16'sh7FFF, 1'b0);
      drain();

      random_total = 0;
      while (random_total < RANDOM_ITEMS) begin
         queue_write(adsr_pkg::REG_NOTE_LENGTH, pick_length());
         queue_write(adsr_pkg::REG_ATTACK, IDX_W'(pick_fraction()));
         queue_write(adsr_pkg::REG_DECAY, IDX_W'(pick_fraction()));
         queue_write(adsr_pkg::REG_SUSTAIN, IDX_W'(pick_fraction()));
         queue_write(adsr_pkg::REG_RELEASE, IDX_W'(pick_fraction()));
         if ($urandom_range(0, 3) == 0)
            queue_write(adsr_pkg::CSR_INDEX_BITS'($urandom_range(REG_SPARE_FIRST,
                                                                 REG_SPARE_LAST)),
                        IDX_W'($urandom));
         write_registers();
         burst = $urandom_range(40, 100);
         repeat (burst) add_sample(random_sample(), $urandom_range(0, 39) == 0);
         random_total += burst;
         drain();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      if (failures == 0 && expected_shaped.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/core/adsr_pkg.sv
rtl/core/adsr_if.sv
rtl/core/adsr_div.sv
rtl/core/adsr_dp.sv
rtl/core/adsr_ctrl.sv
rtl/core/adsr_envelope_shaper_top.sv
rtl/core/adsr_checker.sv
tb/adsr_envelope_shaper_top_tb.sv
